// ----- sv/mafh_pkg.sv -----
// mafh_pkg: constants, register codes and helper functions for the mesh address block
// used by mesh_address_from_hash and its checker; no dependencies
package mafh_pkg;

  // digest storage and address geometry
  localparam int ADDR_BYTES  = 16;
  localparam int WORD_BITS   = 64;
  localparam int STORE_WORDS = 6;
  localparam int DIGEST_BITS = STORE_WORDS * WORD_BITS;
  localparam int COUNT_WORDS = 4;
  localparam int TAIL_BITS   = (ADDR_BYTES - 2) * 8;
  localparam int UPPER_TAIL  = TAIL_BITS - WORD_BITS;
  localparam int COUNT_W     = 9;

  localparam logic [7:0]         PREFIX_BYTE = 8'h02;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 9'd256;

  // configuration register map
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] REG_BEST_FLOOR = 3'd0;

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [DIGEST_BITS-1:0] digest_t;
  typedef logic [COUNT_W-1:0]     count_t;

  // leading one bits of a word that is not all ones, binary search in six steps
  function automatic logic [5:0] lead_ones64(input word_t w);
    word_t      x;
    word_t      m;
    logic [5:0] n;
    x = w;
    n = '0;
    for (int j = 0; j < 6; j++) begin
      m = ~64'd0 << (64 - (32 >> j));
      if ((x & m) == m) begin
        n = n + 6'(32 >> j);
        x = x << (32 >> j);
      end
    end
    return n;
  endfunction

endpackage

// ----- sv/mesh_address_from_hash.sv -----
// Mesh address derivation: a final digest word passes the stage 1 and stage 2 registers into
// the output register, which puts its upper half on the ports; the lower half follows in the
// cycle after the upper half is taken, given no output stall.
// Digest words are taken one per cycle while in_stall is low; the output register holds each
// address for both halves. Count and shift stages are combinational between the registers.
// Reset (rst, synchronous) clears word count, best count, floor and all valid flags.
module mesh_address_from_hash (
  input  logic                              clk,
  input  logic                              rst,
  // digest word channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [63:0]                       hash_word,
  input  logic                              word_last,
  // address half channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [63:0]                       address_half,
  output logic                              half_last,
  output logic [8:0]                        leading_ones,
  output logic                              new_best,
  output logic                              saturated,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mafh_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // digest store and word counter
  mafh_pkg::word_t  store [mafh_pkg::STORE_WORDS];
  logic [2:0]       word_count;
  logic [7:0]       best_floor;
  mafh_pkg::count_t best_ones;

  // stage 1: digest snapshot
  logic             s1_valid;
  mafh_pkg::digest_t s1_snap;
  // stage 2: snapshot with its count
  logic             s2_valid;
  mafh_pkg::digest_t s2_snap;
  mafh_pkg::count_t s2_count;
  // output register
  logic             o_valid;
  logic             o_phase;
  mafh_pkg::word_t  o_upper;
  mafh_pkg::word_t  o_lower;
  mafh_pkg::count_t o_count;
  logic             o_newb;
  logic             o_sat;

  logic              in_acc;
  logic              s1_go;
  logic              s2_go;
  mafh_pkg::digest_t snap_next;
  mafh_pkg::count_t  count_next;
  logic [8:0]        start;
  mafh_pkg::digest_t shifted;
  logic [mafh_pkg::TAIL_BITS-1:0] tail;
  logic              sat_now;
  logic              newb_now;
  mafh_pkg::word_t   upper_next;
  logic [3:0]        all_w;
  logic [5:0]        lo_w [mafh_pkg::COUNT_WORDS];

  // flow control through the three stages
  always_comb begin
    s2_go    = !o_valid || (o_phase && !out_stall);
    s1_go    = !s2_valid || s2_go;
    in_stall = s1_valid && !s1_go;
    in_acc   = in_valid && !in_stall;
  end

  // snapshot: words stored this digest, the incoming word, zero beyond
  always_comb begin
    for (int i = 0; i < mafh_pkg::STORE_WORDS; i++) begin
      if (3'(i) < word_count) begin
        snap_next[mafh_pkg::DIGEST_BITS-1-mafh_pkg::WORD_BITS*i -: mafh_pkg::WORD_BITS] =
          store[i];
      end else if (3'(i) == word_count) begin
        snap_next[mafh_pkg::DIGEST_BITS-1-mafh_pkg::WORD_BITS*i -: mafh_pkg::WORD_BITS] =
          hash_word;
      end else begin
        snap_next[mafh_pkg::DIGEST_BITS-1-mafh_pkg::WORD_BITS*i -: mafh_pkg::WORD_BITS] =
          '0;
      end
    end
  end

  // store incoming words and track the count
  always_ff @(posedge clk) begin
    if (in_acc && (word_count < 3'(mafh_pkg::STORE_WORDS))) begin
      store[word_count] <= hash_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (in_acc) begin
      if (word_last) begin
        word_count <= '0;
      end else if (word_count < 3'(mafh_pkg::STORE_WORDS)) begin
        word_count <= word_count + 3'd1;
      end
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc && word_last) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && word_last) begin
      s1_snap <= snap_next;
    end
  end

  // leading ones over the first four words
  always_comb begin
    for (int k = 0; k < mafh_pkg::COUNT_WORDS; k++) begin
      all_w[k] = &s1_snap[mafh_pkg::DIGEST_BITS-1-mafh_pkg::WORD_BITS*k -: mafh_pkg::WORD_BITS];
      lo_w[k]  = mafh_pkg::lead_ones64(
                   s1_snap[mafh_pkg::DIGEST_BITS-1-mafh_pkg::WORD_BITS*k -: mafh_pkg::WORD_BITS]);
    end
    if (!all_w[0]) begin
      count_next = {3'b000, lo_w[0]};
    end else if (!all_w[1]) begin
      count_next = 9'd64 + {3'b000, lo_w[1]};
    end else if (!all_w[2]) begin
      count_next = 9'd128 + {3'b000, lo_w[2]};
    end else if (!all_w[3]) begin
      count_next = 9'd192 + {3'b000, lo_w[3]};
    end else begin
      count_next = mafh_pkg::COUNT_LIMIT;
    end
  end

  // stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_valid && s1_go) begin
      s2_valid <= 1'b1;
    end else if (s2_go) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_go) begin
      s2_snap  <= s1_snap;
      s2_count <= count_next;
    end
  end

  // address bits after the first zero bit, and the best-count compare
  always_comb begin
    start      = s2_count + 9'd1;
    shifted    = s2_snap << start;
    tail       = shifted[mafh_pkg::DIGEST_BITS-1 -: mafh_pkg::TAIL_BITS];
    sat_now    = (s2_count == mafh_pkg::COUNT_LIMIT);
    newb_now   = (s2_count > best_ones) && (s2_count > {1'b0, best_floor});
    upper_next = {mafh_pkg::PREFIX_BYTE, s2_count[7:0],
                  tail[mafh_pkg::TAIL_BITS-1 -: mafh_pkg::UPPER_TAIL]};
  end

  // output register, upper half then lower half
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      o_phase <= 1'b0;
    end else if (s2_valid && s2_go) begin
      o_valid <= 1'b1;
      o_phase <= 1'b0;
    end else if (o_valid && !out_stall) begin
      if (o_phase) begin
        o_valid <= 1'b0;
        o_phase <= 1'b0;
      end else begin
        o_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_go) begin
      o_upper <= sat_now ? '0 : upper_next;
      o_lower <= sat_now ? '0 : tail[mafh_pkg::WORD_BITS-1:0];
      o_count <= s2_count;
      o_newb  <= newb_now;
      o_sat   <= sat_now;
    end
  end

  // best count so far
  always_ff @(posedge clk) begin
    if (rst) begin
      best_ones <= '0;
    end else if (s2_valid && s2_go && newb_now) begin
      best_ones <= s2_count;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      best_floor <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == mafh_pkg::REG_BEST_FLOOR)) begin
      best_floor <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == mafh_pkg::REG_BEST_FLOOR) ? {24'd0, best_floor} : 32'd0;

  // result ports
  assign out_valid    = o_valid;
  assign address_half = o_phase ? o_lower : o_upper;
  assign half_last    = o_phase;
  assign leading_ones = o_count;
  assign new_best     = o_newb;
  assign saturated    = o_sat;

endmodule

// ----- sv/mafh_check.sv -----
// mafh_check: port-level checks for mesh_address_from_hash, with its bind
// depends on mafh_pkg
module mafh_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] address_half,
  input logic        half_last,
  input logic [8:0]  leading_ones,
  input logic        saturated
);

  // an upper half taken is followed at once by its lower half
  a_lower_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !half_last) |=> (out_valid && half_last))
    else $error("lower half missing after upper half");

  // both halves of one address carry the same count
  a_count_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !half_last) |=> (leading_ones == $past(leading_ones)))
    else $error("count changed between halves");

  // saturation gives a zero address and the full count
  a_sat_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (address_half == 64'd0 && leading_ones == mafh_pkg::COUNT_LIMIT))
    else $error("saturated result not zero");

  // upper half opens with the prefix byte and the count
  a_upper_head: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !saturated && !half_last) |->
      (address_half[63:56] == mafh_pkg::PREFIX_BYTE &&
       address_half[55:48] == leading_ones[7:0]))
    else $error("upper half prefix or count wrong");

endmodule

bind mesh_address_from_hash mafh_check u_mafh_check (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .address_half (address_half),
  .half_last    (half_last),
  .leading_ones (leading_ones),
  .saturated    (saturated)
);

// ----- tb/mafh_checker.sv -----
// mafh_checker: watches the digest, address and configuration ports of the mesh address block,
// predicts every address half and compares it; depends on mafh_pkg for widths and register codes
module mafh_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [63:0]                  hash_word,
  input  logic                         word_last,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [63:0]                  address_half,
  input  logic                         half_last,
  input  logic [8:0]                   leading_ones,
  input  logic                         new_best,
  input  logic                         saturated,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mafh_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic [31:0]                  prdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    mafh_pkg::word_t  half;
    logic             last;
    mafh_pkg::count_t ones;
    logic             best;
    logic             sat;
  } addr_half_t;

  addr_half_t       expected_halves[$];
  mafh_pkg::word_t  digest_words[mafh_pkg::STORE_WORDS];
  int unsigned      words_held;
  mafh_pkg::count_t best_count;
  logic [7:0]       floor_value;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // leading ones up to the limit, then the tail bits after the first zero
  function automatic void derive_address(input mafh_pkg::digest_t dg,
                                         output mafh_pkg::count_t ones,
                                         output mafh_pkg::word_t upper,
                                         output mafh_pkg::word_t lower);
    mafh_pkg::digest_t              shifted;
    logic [mafh_pkg::TAIL_BITS-1:0] tail;
    ones = '0;
    while (ones < mafh_pkg::COUNT_LIMIT && dg[mafh_pkg::DIGEST_BITS-1-int'(ones)])
      ones = ones + 1'b1;
    if (ones == mafh_pkg::COUNT_LIMIT) begin
      upper = '0;
      lower = '0;
    end else begin
      shifted = dg << (int'(ones) + 1);
      tail    = shifted[mafh_pkg::DIGEST_BITS-1 -: mafh_pkg::TAIL_BITS];
      upper   = {mafh_pkg::PREFIX_BYTE, ones[7:0],
                 tail[mafh_pkg::TAIL_BITS-1 -: mafh_pkg::UPPER_TAIL]};
      lower   = tail[mafh_pkg::WORD_BITS-1:0];
    end
  endfunction

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : watch
    addr_half_t        got;
    addr_half_t        want;
    mafh_pkg::digest_t dg;
    mafh_pkg::count_t  ones;
    mafh_pkg::word_t   upper;
    mafh_pkg::word_t   lower;
    logic              nb;
    logic              sat;
    if (rst) begin
      expected_halves.delete();
      foreach (digest_words[i]) digest_words[i] = '0;
      words_held  = 0;
      best_count  = '0;
      floor_value = '0;
    end else begin
      // register writes and read-back
      if (psel && penable && pready && paddr == mafh_pkg::REG_BEST_FLOOR) begin
        if (pwrite)
          floor_value = pwdata[7:0];
        else if (prdata !== {24'd0, floor_value})
          report($sformatf("best_floor read expected %h got %h", {24'd0, floor_value}, prdata));
      end

      // address half transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        got.half = address_half;
        got.last = half_last;
        got.ones = leading_ones;
        got.best = new_best;
        got.sat  = saturated;
        if (expected_halves.size() == 0) begin
          report($sformatf("unexpected half %h last %b ones %0d best %b sat %b",
                           got.half, got.last, got.ones, got.best, got.sat));
        end else begin
          want = expected_halves.pop_front();
          if (got !== want)
            report($sformatf({"expected half %h last %b ones %0d best %b sat %b, ",
                              "got half %h last %b ones %0d best %b sat %b"},
                             want.half, want.last, want.ones, want.best, want.sat,
                             got.half, got.last, got.ones, got.best, got.sat));
        end
      end

      // digest word transaction
      if (in_valid && !in_stall) begin
        if (words_held < mafh_pkg::STORE_WORDS) begin
          digest_words[words_held] = hash_word;
          words_held++;
        end
        if (word_last) begin
          // words not written in this digest read as zero
          for (int i = 0; i < mafh_pkg::STORE_WORDS; i++)
            dg[mafh_pkg::DIGEST_BITS-1-mafh_pkg::WORD_BITS*i -: mafh_pkg::WORD_BITS] =
              (i < words_held) ? digest_words[i] : '0;
          derive_address(dg, ones, upper, lower);
          sat = (ones == mafh_pkg::COUNT_LIMIT);
          nb  = (ones > best_count) && (ones > {1'b0, floor_value});
          if (nb)
            best_count = ones;
          expected_halves.push_back('{upper, 1'b0, ones, nb, sat});
          expected_halves.push_back('{lower, 1'b1, ones, nb, sat});
          words_held = 0;
        end
      end
    end
    pending = expected_halves.size();
  end

endmodule

// ----- tb/tb_mesh_address_from_hash.sv -----
// tb_mesh_address_from_hash: drives digests with chosen leading-one runs and random stalls
// into mesh_address_from_hash; depends on mafh_pkg and mafh_checker for prediction
module tb_mesh_address_from_hash;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_WORDS   = 400;
  localparam int PATTERN_BITS  = 9 * mafh_pkg::WORD_BITS;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic [63:0]                  hash_word;
  logic                         word_last;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [63:0]                  address_half;
  logic                         half_last;
  logic [8:0]                   leading_ones;
  logic                         new_best;
  logic                         saturated;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [mafh_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  int          fail_count;
  int          pending;
  int unsigned words_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  phase_floor[4];

  mesh_address_from_hash DUT (.*);

  mafh_checker address_check (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stall: short runs mostly, some long stalls, some stall-free stretches
  always @(negedge clk) begin : stall_gen
    int unsigned r;
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else if (r < 80) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else if (r < 90) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end else begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(40, 150);
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // one digest word, after a random gap; called and returns at a falling edge
  task automatic send_word(input mafh_pkg::word_t w, input logic last);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if (r < 60) begin
      gap = 0;
    end else if (r < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    hash_word = w;
    word_last = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // digest whose first ones bits are set and next bit clear; negative ones gives pure noise
  task automatic send_digest(input int unsigned n_words, input int ones);
    logic [PATTERN_BITS-1:0] pattern;
    for (int j = 0; j < PATTERN_BITS / 32; j++)
      pattern[PATTERN_BITS-1-32*j -: 32] = $urandom;
    if (ones >= 0) begin
      for (int i = 0; i < ones && i < PATTERN_BITS; i++)
        pattern[PATTERN_BITS-1-i] = 1'b1;
      if (ones < PATTERN_BITS)
        pattern[PATTERN_BITS-1-ones] = 1'b0;
    end
    for (int j = 0; j < n_words; j++)
      send_word(pattern[PATTERN_BITS-1-mafh_pkg::WORD_BITS*j -: mafh_pkg::WORD_BITS],
                j == n_words - 1);
  endtask

  // hold the sender until every predicted half has come out
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_cycle(input logic wr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = mafh_pkg::REG_BEST_FLOOR;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_floor(input logic [7:0] value);
    apb_cycle(1'b1, {24'd0, value});
    apb_cycle(1'b0, 32'd0);
  endtask

  // mostly six-word digests with a leading-one run that widens over the test
  task automatic random_phase();
    int unsigned start;
    int unsigned r;
    int unsigned n_words;
    int unsigned cap;
    int          ones;
    start = words_sent;
    while (words_sent - start < PHASE_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 70)
        n_words = 6;
      else if (r < 85)
        n_words = $urandom_range(1, 5);
      else
        n_words = $urandom_range(7, 9);
      cap = words_sent * 256 / 1700;
      if (cap > 256)
        cap = 256;
      r = $urandom_range(0, 99);
      if (r < 20)
        ones = -1;
      else if (r < 45)
        ones = $urandom_range(0, 8);
      else
        ones = $urandom_range(0, cap);
      send_digest(n_words, ones);
      if (burst_left == 0 && $urandom_range(0, 9) == 0)
        burst_left = $urandom_range(20, 60);
      if ($urandom_range(0, 99) < 3)
        drain();
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    hash_word = '0;
    word_last = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = mafh_pkg::REG_BEST_FLOOR;
    pwdata    = '0;
    phase_floor[0] = 8'd255;
    phase_floor[1] = 8'($urandom_range(1, 254));
    phase_floor[2] = 8'd0;
    phase_floor[3] = 8'($urandom_range(1, 254));
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero word, one-word and two-word short digests, long digest, word boundary
    set_floor(8'd0);
    send_word('0, 1'b1);
    send_digest(6, 1);
    send_word('1, 1'b1);
    send_word('1, 1'b0);
    send_word(64'h7fff_ffff_ffff_fffe, 1'b1);
    send_digest(8, 3);
    send_digest(2, 63);
    send_digest(2, 64);
    drain();

    // random phases under different floors
    for (int p = 0; p < 4; p++) begin
      set_floor(phase_floor[p]);
      random_phase();
      drain();
    end

    // top counts and saturation, at the highest floor and again at the lowest
    set_floor(8'd255);
    send_digest(6, 255);
    send_digest(6, PATTERN_BITS);
    send_digest(4, PATTERN_BITS);
    send_digest(5, 256);
    drain();
    set_floor(8'd0);
    send_digest(6, 256);
    send_digest(9, 300);
    drain();

    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mafh_pkg.sv
sv/mesh_address_from_hash.sv
sv/mafh_check.sv
tb/mafh_checker.sv
tb/tb_mesh_address_from_hash.sv
